/* rtl/core/brans_pkg.sv */
// shared constants, types and helpers of the binary rans encoder
package brans_pkg;

    // probability resolution and derived scaling
    localparam int unsigned PROB_BITS  = 12;
    localparam int unsigned PROB_W     = 12;
    localparam int unsigned WORD_W     = 16;
    localparam int unsigned STATE_W    = 2 * WORD_W;
    localparam int unsigned FREQ_SHIFT = WORD_W - PROB_BITS;
    localparam logic [WORD_W-1:0]  PROB_MAX   = WORD_W'((1 << PROB_BITS) - 1);
    localparam logic [STATE_W-1:0] STATE_INIT = STATE_W'(1 << WORD_W);

    // divider step count
    localparam int unsigned DIV_STEPS = WORD_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    // input commands
    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FLUSH_HI
    } t_state;

    // request to the divider: numerator below divisor << 16
    typedef struct packed {
        logic               start;
        logic [STATE_W-1:0] num;
        logic [WORD_W-1:0]  den;
    } t_div_req;

    // divider result
    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quot;
        logic [WORD_W-1:0] rem;
    } t_div_rsp;

    // clamp the probability and scale it to the 16-bit total
    function automatic logic [WORD_W-1:0] scale_prob(input logic [PROB_W-1:0] prob);
        logic [WORD_W-1:0] p;
        p = WORD_W'(prob);
        if (p == '0) begin
            p = WORD_W'(1);
        end
        if (p > PROB_MAX) begin
            p = PROB_MAX;
        end
        return p << FREQ_SHIFT;
    endfunction

endpackage

/* rtl/core/brans_if.sv */
// item channels of the binary rans encoder

// input channel: encode or flush commands
interface brans_in_if;
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic                           bit_value;
    logic [brans_pkg::PROB_W-1:0]   prob_scaled;

    modport source (output valid, output command, output bit_value, output prob_scaled,
                    input ready);
    modport sink   (input valid, input command, input bit_value, input prob_scaled,
                    output ready);
endinterface

// output channel: emitted state words
interface brans_out_if;
    logic                           valid;
    logic                           ready;
    logic [brans_pkg::WORD_W-1:0]   chunk;
    logic                           is_last;

    modport source (output valid, output chunk, output is_last, input ready);
    modport sink   (input valid, input chunk, input is_last, output ready);
endinterface

/* rtl/core/brans_div.sv */
// bit-serial restoring divider, 32-bit state by 16-bit frequency
module brans_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  brans_pkg::t_div_req i_req,
    output brans_pkg::t_div_rsp o_rsp
);
    import brans_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [WORD_W-1:0]   r_rem;
    logic [WORD_W-1:0]   r_quo;
    logic [WORD_W-1:0]   r_den;

    logic [WORD_W:0]     n_trial;
    logic                n_qbit;
    logic [WORD_W-1:0]   n_rem;

    // one quotient bit per cycle
    always_comb begin
        n_trial = {r_rem, r_quo[WORD_W-1]};
        n_qbit  = (n_trial >= {1'b0, r_den});
        if (n_qbit) begin
            n_rem = WORD_W'(n_trial - {1'b0, r_den});
        end else begin
            n_rem = n_trial[WORD_W-1:0];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num[STATE_W-1:WORD_W];
            r_quo <= i_req.num[WORD_W-1:0];
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[WORD_W-2:0], n_qbit};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

/* rtl/core/binary_rans_encoder_top.sv */
// binary rans encoder with 16-bit renormalization
//
// Input channel i_in carries one command per item: encode one bit with its
// 12-bit probability of a one, or flush the coder state. Output channel o_out
// carries 16-bit words, is_last set on the final word of an item's run.
// Encode: when the state has reached the bit's frequency << 16 its low word
// is emitted (one word, is_last = 1) the cycle after acceptance; otherwise no
// word. The state update needs one division by the frequency, done by a
// bit-serial divider one quotient bit per cycle, so an encode item occupies
// the block from acceptance through 16 divider steps to one write-back.
// Flush: the low word (is_last = 0) appears the cycle after acceptance and
// the high word (is_last = 1) follows as soon as the first is taken; the
// state then returns to 65536.
// Words wait in an output register; a new item is accepted while a word is
// held only if the receiver takes that word in the same cycle, so a stalled
// receiver holds off the input after at most one pending word.
// Reset (synchronous, active low) sets the state to 65536, empties the output
// register and leaves the block ready.
module binary_rans_encoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    brans_in_if.sink    i_in,
    brans_out_if.source o_out
);
    import brans_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic [STATE_W-1:0]  r_coder;
    logic [WORD_W-1:0]   r_cum;
    logic                r_out_valid;
    logic [WORD_W-1:0]   r_chunk;
    logic                r_last;

    logic                out_free;
    logic                in_take;
    logic [WORD_W-1:0]   scaled;
    logic [WORD_W-1:0]   freq;
    logic [WORD_W-1:0]   cum;
    logic                renorm;
    logic                load_out;
    logic [WORD_W-1:0]   load_chunk;
    logic                load_last;
    t_div_req            div_req;
    t_div_rsp            div_rsp;

    // frequency and cumulative start of the incoming bit
    always_comb begin
        scaled = scale_prob(i_in.prob_scaled);
        if (i_in.bit_value) begin
            freq = scaled;
            cum  = WORD_W'(0) - scaled;
        end else begin
            freq = WORD_W'(0) - scaled;
            cum  = '0;
        end
        renorm = (r_coder[STATE_W-1:WORD_W] >= freq);
    end

    assign out_free   = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE) && out_free;
    assign in_take    = i_in.valid && i_in.ready;

    // next state and output loads
    always_comb begin
        n_state       = r_state;
        load_out      = 1'b0;
        load_chunk    = r_coder[WORD_W-1:0];
        load_last     = 1'b1;
        div_req.start = 1'b0;
        div_req.den   = freq;
        div_req.num   = r_coder;
        if (renorm) begin
            div_req.num = {{WORD_W{1'b0}}, r_coder[STATE_W-1:WORD_W]};
        end
        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    if (i_in.command == CMD_FLUSH) begin
                        load_out  = 1'b1;
                        load_last = 1'b0;
                        n_state   = ST_FLUSH_HI;
                    end else begin
                        load_out      = renorm;
                        div_req.start = 1'b1;
                        n_state       = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FLUSH_HI: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    load_chunk = r_coder[STATE_W-1:WORD_W];
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // coder state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coder <= STATE_INIT;
        end else if (r_state == ST_DIV && div_rsp.done) begin
            r_coder <= {div_rsp.quot, div_rsp.rem + r_cum};
        end else if (r_state == ST_FLUSH_HI && out_free) begin
            r_coder <= STATE_INIT;
        end
    end

    // cumulative start held for the write-back
    always_ff @(posedge i_clk) begin
        if (div_req.start) begin
            r_cum <= cum;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_chunk <= load_chunk;
            r_last  <= load_last;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.chunk   = r_chunk;
    assign o_out.is_last = r_last;

    brans_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

endmodule

/* tb/sv/binary_rans_encoder_top_test.sv */
// testbench of the binary rans encoder: directed and random items against a built-in predictor
`timescale 1ns / 1ps

module binary_rans_encoder_top_test;
    import brans_pkg::*;

    typedef struct {
        logic [WORD_W-1:0] chunk;
        logic              is_last;
    } t_word;

    localparam int unsigned PROB_TOTAL = 1 << PROB_BITS;
    localparam int unsigned SCALE_SH   = WORD_W - PROB_BITS;

    logic i_clk = 1'b0;
    logic i_rst_n;

    brans_in_if  in_if ();
    brans_out_if out_if ();

    binary_rans_encoder_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // predicted coder state and the words it still owes
    logic [STATE_W-1:0] coder_x;
    t_word              owed_words[$];

    bit idle_on;
    int mismatches;
    int encode_count;
    int flush_count;
    int words_seen;
    int renorm_words;

    // clock
    always #6 i_clk = ~i_clk;

    // run limit
    initial begin
        #10_000_000;
        $display("binary_rans_encoder_top_test: done, errors");
        $finish;
    end

    // receiver: stalls in random bursts while idling is on
    initial begin
        int stall_left;
        stall_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 14);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endfunction

    // append one word to the owed list
    function automatic void owe_word(input logic [WORD_W-1:0] chunk, input logic is_last);
        t_word w;
        w.chunk    = chunk;
        w.is_last  = is_last;
        owed_words = {owed_words, w};
    endfunction

    // work out the words one accepted item owes and advance the coder state
    function automatic void rans_encode_step(input logic cmd, input logic bv,
                                             input logic [PROB_W-1:0] prob);
        bit [63:0] x;
        bit [63:0] freq;
        bit [63:0] cum;
        int unsigned p;
        x = 64'(coder_x);
        if (cmd == CMD_FLUSH) begin
            owe_word(x[15:0], 1'b0);
            owe_word(x[31:16], 1'b1);
            coder_x = STATE_INIT;
            flush_count++;
        end else begin
            // clamp the probability so no frequency is zero
            p = prob;
            if (p < 1) p = 1;
            if (p > PROB_TOTAL - 1) p = PROB_TOTAL - 1;
            freq = 64'(bv ? p : PROB_TOTAL - p) << SCALE_SH;
            cum  = bv ? (64'(PROB_TOTAL - p) << SCALE_SH) : 64'd0;
            // renormalize at most once
            if (x >= (freq << 16)) begin
                owe_word(x[15:0], 1'b1);
                x = x >> 16;
                renorm_words++;
            end
            x = ((x / freq) << 16) + (x % freq) + cum;
            coder_x = x[STATE_W-1:0];
            encode_count++;
        end
    endfunction

    // compare each taken word with the oldest owed word
    always @(posedge i_clk) begin
        t_word want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            words_seen++;
            if (owed_words.size() == 0) begin
                note_mismatch($sformatf("unexpected word chunk=%h is_last=%0b",
                                        out_if.chunk, out_if.is_last));
            end else begin
                want = owed_words.pop_front();
                if (out_if.chunk !== want.chunk || out_if.is_last !== want.is_last) begin
                    note_mismatch($sformatf(
                        "expected chunk=%h is_last=%0b, got chunk=%h is_last=%0b",
                        want.chunk, want.is_last, out_if.chunk, out_if.is_last));
                end
            end
        end
    end

    // send one item; valid stays high so the next item can follow at once
    task automatic send_item(input logic cmd, input logic bv, input logic [PROB_W-1:0] prob);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.command     <= cmd;
        in_if.bit_value   <= bv;
        in_if.prob_scaled <= prob;
        do @(posedge i_clk); while (!in_if.ready);
        rans_encode_step(cmd, bv, prob);
    endtask

    task automatic send_encode(input logic bv, input logic [PROB_W-1:0] prob);
        send_item(CMD_ENCODE, bv, prob);
    endtask

    task automatic send_flush();
        send_item(CMD_FLUSH, 1'($urandom_range(0, 1)), PROB_W'($urandom_range(0, 4095)));
    endtask

    // drop valid and wait until every owed word has come out
    task automatic drain_words();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (owed_words.size() != 0) @(posedge i_clk);
    endtask

    // flush straight after reset gives the initial state
    task automatic test_flush_after_reset();
        send_item(CMD_FLUSH, 1'b0, '0);
        send_item(CMD_FLUSH, 1'b1, '1);
        drain_words();
    endtask

    // probability extremes, zero clamped to one, both bit values
    task automatic test_prob_extremes();
        send_encode(1'b0, 12'd0);
        send_encode(1'b1, 12'd0);
        send_encode(1'b0, 12'd1);
        send_encode(1'b1, 12'd1);
        send_encode(1'b0, 12'd4095);
        send_encode(1'b1, 12'd4095);
        send_encode(1'b0, 12'd2048);
        send_encode(1'b1, 12'd2048);
        send_flush();
        drain_words();
    endtask

    // a very unlikely bit keeps the frequency small, so the state renormalizes
    task automatic test_renorm();
        repeat (4) send_encode(1'b0, 12'd4095);
        send_flush();
        drain_words();
    endtask

    // flush ignores its bit and probability fields
    task automatic test_flush_fields();
        send_encode(1'b1, 12'd7);
        send_flush();
        send_flush();
        send_flush();
        drain_words();
    endtask

    // random items: runs of encodes with skewed or uniform probabilities, flushes between
    task automatic test_random(input int count);
        logic [PROB_W-1:0] prob;
        logic              bv;
        repeat (count) begin
            case ($urandom_range(0, 3))
                0: prob = PROB_W'($urandom_range(0, 15));
                1: prob = PROB_W'($urandom_range(4080, 4095));
                default: prob = PROB_W'($urandom_range(0, 4095));
            endcase
            // half the bits follow their probability, the rest are fair coin flips
            if ($urandom_range(0, 1) == 0) begin
                bv = ($urandom_range(1, 4096) <= prob);
            end else begin
                bv = 1'($urandom_range(0, 1));
            end
            if ($urandom_range(0, 29) == 0) begin
                send_flush();
            end else begin
                send_encode(bv, prob);
            end
        end
        send_flush();
        drain_words();
    endtask

    initial begin
        idle_on = 1'b1;
        mismatches = 0;
        encode_count = 0;
        flush_count = 0;
        words_seen = 0;
        renorm_words = 0;
        coder_x = STATE_INIT;
        i_rst_n <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.command <= CMD_ENCODE;
        in_if.bit_value <= 1'b0;
        in_if.prob_scaled <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_flush_after_reset();
        test_prob_extremes();
        test_renorm();
        test_flush_fields();
        test_random(1500);
        // last part runs without idling
        idle_on = 1'b0;
        test_random(150);

        repeat (40) @(posedge i_clk);
        if (owed_words.size() != 0) begin
            note_mismatch($sformatf("%0d words never arrived", owed_words.size()));
        end
        $display("covered %0d encode items and %0d flush items", encode_count, flush_count);
        $display("checked %0d words, %0d of them from renormalization, %0d mismatches",
                 words_seen, renorm_words, mismatches);
        if (mismatches == 0) begin
            $display("binary_rans_encoder_top_test: done, clean");
        end else begin
            $display("binary_rans_encoder_top_test: done, errors");
        end
        $finish;
    end

endmodule

/* binary_rans_encoder_top.f */
rtl/core/brans_pkg.sv
rtl/core/brans_if.sv
rtl/core/brans_div.sv
rtl/core/binary_rans_encoder_top.sv
tb/sv/binary_rans_encoder_top_test.sv
